### rtl/core/modbus_read_input_regs_reply_parser_top_defines.svh
// Assertion macros for the reply parser modules; mbrir_fifo includes them.
`ifndef MODBUS_READ_INPUT_REGS_REPLY_PARSER_TOP_DEFINES_SVH
`define MODBUS_READ_INPUT_REGS_REPLY_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MBRIR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reply parser check failed");

// Next-cycle implication.
`define MBRIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reply parser check failed");

`endif

### rtl/core/mbrir_pkg.sv
// Types and constants of the Modbus input-register reply parser.
package mbrir_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // function codes
   localparam logic [7:0] FC_READ_IREGS = 8'h04;
   localparam logic [7:0] FC_EXC_FLAG   = 8'h80;

   // frame status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SLAVE = 3'd1;
   localparam logic [2:0] ST_TRUNC = 3'd2;
   localparam logic [2:0] ST_COUNT = 3'd3;
   localparam logic [2:0] ST_FUNC  = 3'd4;
   localparam logic [2:0] ST_EXC   = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_START_ADDRESS  = 2'd1;
   localparam logic [1:0] CSR_REGISTER_COUNT = 2'd2;

   // one queue entry: the results caused by one byte
   typedef struct packed {
      logic        has_value;
      logic [15:0] reg_address;
      logic [15:0] reg_value;
      logic        has_status;
      logic [2:0]  status;
      logic [7:0]  exception_code;
   } mbrir_entry_type;

endpackage

### rtl/core/mbrir_req_if.sv
// Byte input channel.
interface mbrir_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/mbrir_rsp_if.sv
// Result output channel.
interface mbrir_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_value;
   logic [15:0] reg_address;
   logic [15:0] reg_value;
   logic [7:0]  exception_code;
   logic [2:0]  status;
   logic        frame_end;

   modport source (output valid, output is_value, output reg_address, output reg_value,
                   output exception_code, output status, output frame_end, input ready);
   modport sink   (input valid, input is_value, input reg_address, input reg_value,
                   input exception_code, input status, input frame_end, output ready);
endinterface

### rtl/core/mbrir_csr_if.sv
// Configuration write channel.
interface mbrir_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/modbus_read_input_regs_reply_parser_top.sv
// Top level of the Modbus read-input-registers reply parser.
//
//   channel  dir  payload                                           transfer when
//   req      in   data_byte, last_byte                              valid & ready
//   rsp      out  is_value, reg_address, reg_value, exception_code, valid & ready
//                 status, frame_end
//   csr      in   index (0 slave, 1 start, 2 count), data           valid & ready
//
// One byte per cycle is taken while the four-entry queue has room.
// A result reaches rsp by way of the queue, written on its byte's transfer edge,
// and then the output register, loaded when it is empty or rsp.ready is high; a
// byte that closes a frame on a register's low byte yields two results and holds
// the output port for both, the value result first and the status result after.
// Reset is synchronous: parser back to the address byte, config to its
// reset values, queue and output register empty.
// A stalled rsp fills the queue, which then drops req.ready; csr is always ready.
module modbus_read_input_regs_reply_parser_top (
   input  logic       clock,
   input  logic       reset,
   mbrir_req_if.sink  req,
   mbrir_rsp_if.source rsp,
   mbrir_csr_if.sink  csr
);
   import mbrir_pkg::*;

   // front to queue
   logic            push;
   mbrir_entry_type push_entry;
   logic            queue_full;

   // queue to back
   logic            pop;
   mbrir_entry_type head_entry;
   logic            queue_empty;

   // byte parsing and config registers
   mbrir_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples parsing from result delivery
   mbrir_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // value result first, then status result, through the output register
   mbrir_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

### rtl/core/mbrir_front.sv
// Front end: configuration registers and per-byte frame parsing.
module mbrir_front (
   input  logic                     clock,
   input  logic                     reset,
   mbrir_req_if.sink                req,
   mbrir_csr_if.sink                csr,
   input  logic                     queue_full,
   output logic                     push,
   output mbrir_pkg::mbrir_entry_type push_entry
);
   import mbrir_pkg::*;

   localparam logic [2:0] PH_ADDR  = 3'd0;
   localparam logic [2:0] PH_FUNC  = 3'd1;
   localparam logic [2:0] PH_COUNT = 3'd2;
   localparam logic [2:0] PH_HIGH  = 3'd3;
   localparam logic [2:0] PH_LOW   = 3'd4;
   localparam logic [2:0] PH_EXC   = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   logic [7:0]  slave_address_ff, slave_address_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [6:0]  register_count_ff, register_count_in;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  frame_status_ff, frame_status_in;
   logic [6:0]  regs_left_ff, regs_left_in;
   logic [15:0] next_address_ff, next_address_in;
   logic [7:0]  high_hold_ff, high_hold_in;
   logic [7:0]  exc_hold_ff, exc_hold_in;

   logic        accept;
   logic [2:0]  final_status;

   assign csr.ready = 1'b1;
   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;

   always_comb begin
      slave_address_in  = slave_address_ff;
      start_address_in  = start_address_ff;
      register_count_in = register_count_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_SLAVE_ADDRESS:  slave_address_in  = csr.data[7:0];
            CSR_START_ADDRESS:  start_address_in  = csr.data;
            CSR_REGISTER_COUNT: register_count_in = csr.data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      frame_status_in = frame_status_ff;
      regs_left_in    = regs_left_ff;
      next_address_in = next_address_ff;
      high_hold_in    = high_hold_ff;
      exc_hold_in     = exc_hold_ff;
      final_status    = ST_OK;
      push_entry      = '0;

      unique case (phase_ff)
         PH_ADDR: begin
            if (req.data_byte != slave_address_ff) begin
               frame_status_in = ST_SLAVE;
               phase_in        = PH_DONE;
            end else begin
               phase_in = PH_FUNC;
            end
         end
         PH_FUNC: begin
            if (req.data_byte == FC_READ_IREGS) begin
               phase_in = PH_COUNT;
            end else if (req.data_byte == (FC_READ_IREGS | FC_EXC_FLAG)) begin
               phase_in = PH_EXC;
            end else begin
               frame_status_in = ST_FUNC;
               phase_in        = PH_DONE;
            end
         end
         PH_COUNT: begin
            if (req.data_byte != {register_count_ff, 1'b0}) begin
               frame_status_in = ST_COUNT;
               phase_in        = PH_DONE;
            end else begin
               regs_left_in    = register_count_ff;
               next_address_in = start_address_ff;
               phase_in        = (register_count_ff == 7'd0) ? PH_DONE : PH_HIGH;
            end
         end
         PH_HIGH: begin
            high_hold_in = req.data_byte;
            phase_in     = PH_LOW;
         end
         PH_LOW: begin
            push_entry.has_value   = 1'b1;
            push_entry.reg_address = next_address_ff;
            push_entry.reg_value   = {high_hold_ff, req.data_byte};
            next_address_in        = next_address_ff + 16'd1;
            regs_left_in           = regs_left_ff - 7'd1;
            phase_in               = (regs_left_in == 7'd0) ? PH_DONE : PH_HIGH;
         end
         PH_EXC: begin
            exc_hold_in     = req.data_byte;
            frame_status_in = ST_EXC;
            phase_in        = PH_DONE;
         end
         default: phase_in = PH_DONE;
      endcase

      if (req.last_byte) begin
         final_status = frame_status_in;
         if (final_status == ST_OK && phase_in != PH_DONE) begin
            final_status = ST_TRUNC;
         end
         push_entry.has_status     = 1'b1;
         push_entry.status         = final_status;
         push_entry.exception_code = (final_status == ST_EXC) ? exc_hold_in : 8'd0;
         phase_in        = PH_ADDR;
         frame_status_in = ST_OK;
         regs_left_in    = 7'd0;
         high_hold_in    = 8'd0;
         exc_hold_in     = 8'd0;
      end
   end

   assign push = accept && (push_entry.has_value || push_entry.has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff  <= 8'd1;
         start_address_ff  <= 16'd0;
         register_count_ff <= 7'd1;
         phase_ff          <= PH_ADDR;
         frame_status_ff   <= ST_OK;
      end else begin
         slave_address_ff  <= slave_address_in;
         start_address_ff  <= start_address_in;
         register_count_ff <= register_count_in;
         if (accept) begin
            phase_ff        <= phase_in;
            frame_status_ff <= frame_status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         regs_left_ff    <= regs_left_in;
         next_address_ff <= next_address_in;
         high_hold_ff    <= high_hold_in;
         exc_hold_ff     <= exc_hold_in;
      end
   end

endmodule

### rtl/core/mbrir_fifo.sv
// Short queue between the parser front and the result back end.
`include "modbus_read_input_regs_reply_parser_top_defines.svh"
module mbrir_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mbrir_pkg::mbrir_entry_type push_entry,
   input  logic                     pop,
   output mbrir_pkg::mbrir_entry_type head_entry,
   output logic                     full,
   output logic                     empty
);
   import mbrir_pkg::*;

   mbrir_entry_type         slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + (QUEUE_AW)'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + (QUEUE_AW)'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `MBRIR_ASSERT_NOW(a_no_push_full, clock, reset, push, !full)
   `MBRIR_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !empty)
   `MBRIR_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
   `MBRIR_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + (QUEUE_AW+1)'(1))

endmodule

### rtl/core/mbrir_back.sv
// Back end: splits queue entries into results and holds the output register.
module mbrir_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mbrir_pkg::mbrir_entry_type head_entry,
   input  logic                     empty,
   output logic                     pop,
   mbrir_rsp_if.source              rsp
);
   import mbrir_pkg::*;

   logic        value_sent_ff, value_sent_in;
   logic        valid_ff, valid_in;
   logic        is_value_ff;
   logic [15:0] reg_address_ff;
   logic [15:0] reg_value_ff;
   logic [7:0]  exception_code_ff;
   logic [2:0]  status_ff;
   logic        frame_end_ff;

   logic        load;
   logic        part_is_value;
   logic        last_part;

   assign part_is_value = head_entry.has_value && !value_sent_ff;
   assign last_part     = !part_is_value || !head_entry.has_status;
   assign load          = !empty && (!valid_ff || rsp.ready);
   assign pop           = load && last_part;

   always_comb begin
      value_sent_in = value_sent_ff;
      if (load) begin
         value_sent_in = part_is_value && !last_part;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         value_sent_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         value_sent_ff <= value_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         is_value_ff       <= part_is_value;
         reg_address_ff    <= part_is_value ? head_entry.reg_address : 16'd0;
         reg_value_ff      <= part_is_value ? head_entry.reg_value : 16'd0;
         exception_code_ff <= part_is_value ? 8'd0 : head_entry.exception_code;
         status_ff         <= part_is_value ? ST_OK : head_entry.status;
         frame_end_ff      <= !part_is_value;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.is_value       = is_value_ff;
   assign rsp.reg_address    = reg_address_ff;
   assign rsp.reg_value      = reg_value_ff;
   assign rsp.exception_code = exception_code_ff;
   assign rsp.status         = status_ff;
   assign rsp.frame_end      = frame_end_ff;

endmodule
